@@ hdl/julia_escape_time_pixel_defines.svh @@
// ----------------------------------------------------------------------------
// Julia escape time pixel assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Checked only outside reset.
`define JETP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define JETP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/jetp_pkg.sv @@
// ----------------------------------------------------------------------------
// Julia escape time pixel package
// Widths, register map, reset values, shared types and saturation.
// ----------------------------------------------------------------------------
package jetp_pkg;

  localparam int COORD_W = 12;
  localparam int Q_W     = 32;
  localparam int STEP_W  = 31;
  localparam int ITER_W  = 16;
  localparam int CFG_IDX_W = 3;

  localparam int FRAC_BITS = 28;
  localparam logic [63:0] ESCAPE_Q56 = 64'd4 << 56;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_REAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_IMAG  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd5;

  localparam logic signed [Q_W-1:0] RST_ORIGIN_REAL = -32'sd539587461;
  localparam logic signed [Q_W-1:0] RST_ORIGIN_IMAG = -32'sd394264;
  localparam logic [STEP_W-1:0]     RST_PIXEL_STEP  = 31'd789333;
  localparam logic signed [Q_W-1:0] RST_CONST_REAL  = 32'sd0;
  localparam logic signed [Q_W-1:0] RST_CONST_IMAG  = -32'sd214748365;
  localparam logic [ITER_W-1:0]     RST_MAX_ITER    = 16'd512;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [Q_W-1:0] origin_real;
    logic signed [Q_W-1:0] origin_imag;
    logic [STEP_W-1:0]     pixel_step;
    logic signed [Q_W-1:0] const_real;
    logic signed [Q_W-1:0] const_imag;
    logic [ITER_W-1:0]     max_iter;
  } cfg_t;

  typedef struct packed {
    logic signed [Q_W-1:0] zr;
    logic signed [Q_W-1:0] zi;
    logic [COORD_W-1:0]    column;
    logic [COORD_W-1:0]    row;
  } item_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [Q_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/jetp_if.sv @@
// ----------------------------------------------------------------------------
// Julia escape time pixel channels
// Pixel input, count output and register write channels.
// ----------------------------------------------------------------------------
interface jetp_in_if;
  logic                           valid;
  logic                           ready;
  logic [jetp_pkg::COORD_W-1:0]   column;
  logic [jetp_pkg::COORD_W-1:0]   row;
  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

interface jetp_out_if;
  logic                           valid;
  logic                           ready;
  logic [jetp_pkg::COORD_W-1:0]   out_column;
  logic [jetp_pkg::COORD_W-1:0]   out_row;
  logic [jetp_pkg::ITER_W-1:0]    iteration_count;
  modport source (output valid, out_column, out_row, iteration_count, input ready);
  modport sink   (input valid, out_column, out_row, iteration_count, output ready);
endinterface

interface jetp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [jetp_pkg::CFG_IDX_W-1:0] index;
  logic [jetp_pkg::Q_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/jetp_cfg.sv @@
// ----------------------------------------------------------------------------
// Julia escape time pixel register file
// Holds the view window, Julia constant and iteration limit.
// ----------------------------------------------------------------------------
module jetp_cfg (
  input  logic             clk,
  input  logic             rst,
  jetp_cfg_if.sink         cfg,
  output jetp_pkg::cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.origin_real <= jetp_pkg::RST_ORIGIN_REAL;
      regs.origin_imag <= jetp_pkg::RST_ORIGIN_IMAG;
      regs.pixel_step  <= jetp_pkg::RST_PIXEL_STEP;
      regs.const_real  <= jetp_pkg::RST_CONST_REAL;
      regs.const_imag  <= jetp_pkg::RST_CONST_IMAG;
      regs.max_iter    <= jetp_pkg::RST_MAX_ITER;
    end else if (cfg.valid) begin
      case (cfg.index)
        jetp_pkg::REG_ORIGIN_REAL: regs.origin_real <= $signed(cfg.data);
        jetp_pkg::REG_ORIGIN_IMAG: regs.origin_imag <= $signed(cfg.data);
        jetp_pkg::REG_PIXEL_STEP:  regs.pixel_step  <= cfg.data[jetp_pkg::STEP_W-1:0];
        jetp_pkg::REG_CONST_REAL:  regs.const_real  <= $signed(cfg.data);
        jetp_pkg::REG_CONST_IMAG:  regs.const_imag  <= $signed(cfg.data);
        jetp_pkg::REG_MAX_ITER:    regs.max_iter    <= cfg.data[jetp_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/jetp_front.sv @@
// ----------------------------------------------------------------------------
// Julia escape time pixel front end
// Accepts pixel transactions and maps them to a saturated start point.
// ----------------------------------------------------------------------------
module jetp_front (
  input  logic             clk,
  input  logic             rst,
  jetp_in_if.sink          pix_in,
  input  jetp_pkg::cfg_t   regs,
  output jetp_pkg::item_t  item,
  output logic             item_valid,
  input  logic             item_ready
);

  logic [42:0]        prod_re;
  logic [42:0]        prod_im;
  logic signed [43:0] sum_re;
  logic signed [43:0] sum_im;
  logic               take;

  assign pix_in.ready = !item_valid || item_ready;
  assign take = pix_in.valid && pix_in.ready;

  assign prod_re = 43'(regs.pixel_step) * 43'(pix_in.column);
  assign prod_im = 43'(regs.pixel_step) * 43'(pix_in.row);
  assign sum_re  = 44'(regs.origin_real) + $signed(44'(prod_re));
  assign sum_im  = 44'(regs.origin_imag) + $signed(44'(prod_im));

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.zr     <= jetp_pkg::sat32(64'(sum_re));
      item.zi     <= jetp_pkg::sat32(64'(sum_im));
      item.column <= pix_in.column;
      item.row    <= pix_in.row;
    end
  end

endmodule

@@ hdl/jetp_queue.sv @@
// ----------------------------------------------------------------------------
// Julia escape time pixel queue
// Short FIFO between front end and iteration engine.
// ----------------------------------------------------------------------------
module jetp_queue (
  input  logic             clk,
  input  logic             rst,
  input  jetp_pkg::item_t  push_item,
  input  logic             push_valid,
  output logic             push_ready,
  output jetp_pkg::item_t  pop_item,
  output logic             pop_valid,
  input  logic             pop_ready
);

  jetp_pkg::item_t                 store [jetp_pkg::QUEUE_DEPTH];
  logic [jetp_pkg::QPTR_W-1:0]     wr_ptr;
  logic [jetp_pkg::QPTR_W-1:0]     rd_ptr;
  logic [jetp_pkg::QCNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = count != jetp_pkg::QCNT_W'(jetp_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == jetp_pkg::QPTR_W'(jetp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == jetp_pkg::QPTR_W'(jetp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hdl/jetp_back.sv @@
// ----------------------------------------------------------------------------
// Julia escape time pixel iteration engine
// Runs z = z^2 + c until escape or the limit, then registers the count.
// ----------------------------------------------------------------------------
module jetp_back (
  input  logic             clk,
  input  logic             rst,
  input  jetp_pkg::cfg_t   regs,
  input  jetp_pkg::item_t  q_item,
  input  logic             q_valid,
  output logic             q_ready,
  jetp_out_if.source       pix_out
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                      state;
  logic signed [jetp_pkg::Q_W-1:0] zr;
  logic signed [jetp_pkg::Q_W-1:0] zi;
  logic [jetp_pkg::COORD_W-1:0]    column;
  logic [jetp_pkg::COORD_W-1:0]    row;
  logic [jetp_pkg::ITER_W-1:0]     iter;
  logic signed [63:0]              rr;
  logic signed [63:0]              ii;
  logic signed [63:0]              ri;

  logic [63:0]                     sq_sum;
  logic signed [63:0]              diff;
  logic signed [36:0]              re_sum;
  logic signed [37:0]              im_sum;
  logic                            out_free;

  assign q_ready  = state == S_IDLE;
  assign out_free = !pix_out.valid || pix_out.ready;

  assign sq_sum = 64'(rr) + 64'(ii);
  assign diff   = rr - ii;
  assign re_sum = 37'($signed(diff[63:jetp_pkg::FRAC_BITS])) + 37'(regs.const_real);
  assign im_sum = 38'($signed(ri[63:jetp_pkg::FRAC_BITS-1])) + 38'(regs.const_imag);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pix_out.valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        pix_out.valid <= 1'b1;
      end else if (pix_out.ready) begin
        pix_out.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= (iter == regs.max_iter) ? S_DONE : S_UPD;
        end
        S_UPD: begin
          state <= (sq_sum >= jetp_pkg::ESCAPE_Q56) ? S_DONE : S_MUL;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          zr     <= q_item.zr;
          zi     <= q_item.zi;
          column <= q_item.column;
          row    <= q_item.row;
          iter   <= '0;
        end
      end
      S_MUL: begin
        rr <= zr * zr;
        ii <= zi * zi;
        ri <= zr * zi;
      end
      S_UPD: begin
        if (sq_sum < jetp_pkg::ESCAPE_Q56) begin
          zr   <= jetp_pkg::sat32(64'(re_sum));
          zi   <= jetp_pkg::sat32(64'(im_sum));
          iter <= iter + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          pix_out.out_column      <= column;
          pix_out.out_row         <= row;
          pix_out.iteration_count <= iter;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/julia_escape_time_pixel.sv @@
// ----------------------------------------------------------------------------
// Julia escape time pixel engine
// A pixel transaction (column, row) returns one count transaction with the
// pixel's Julia set escape count. The front end takes a pixel and maps it
// to its start point; a two-entry queue holds start points for the iteration
// engine. Each iteration runs through S_MUL (the two squares and the cross
// product) and S_UPD (the escape compare and update). A stall on the count
// output holds the engine in S_DONE. Register writes are taken at any time
// and must only be issued while no pixel is in flight.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel (
  input  logic        clk,
  input  logic        rst,
  jetp_in_if.sink     pix_in,
  jetp_out_if.source  pix_out,
  jetp_cfg_if.sink    cfg
);

  jetp_pkg::cfg_t  regs;
  jetp_pkg::item_t f_item;
  logic            f_valid;
  logic            f_ready;
  jetp_pkg::item_t q_item;
  logic            q_valid;
  logic            q_ready;

  jetp_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  jetp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pix_in     (pix_in),
    .regs       (regs),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  jetp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (f_item),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_item   (q_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  jetp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .pix_out (pix_out)
  );

endmodule

@@ hdl/jetp_chk.sv @@
// ----------------------------------------------------------------------------
// Julia escape time pixel port checker
// Port-level properties on transaction ordering and output stability.
// ----------------------------------------------------------------------------
`include "julia_escape_time_pixel_defines.svh"

module jetp_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [jetp_pkg::COORD_W-1:0]   out_column,
  input logic [jetp_pkg::COORD_W-1:0]   out_row,
  input logic [jetp_pkg::ITER_W-1:0]    iteration_count,
  input logic                           cfg_ready
);

  logic [3:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  `JETP_ASSERT_ALWAYS(a_no_out_after_reset, rst |=> !out_valid, "output valid after reset")
  `JETP_ASSERT(a_out_has_pixel, out_valid |-> pending != 4'd0, "result without pending pixel")
  `JETP_ASSERT(a_bounded_in_flight, pending <= 4'd5, "too many pixels in flight")
  `JETP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_column) && $stable(out_row) && $stable(iteration_count), "stalled result changed")
  `JETP_ASSERT(a_cfg_ready, !$past(rst) |-> cfg_ready, "register port not ready")

endmodule

bind julia_escape_time_pixel jetp_chk u_jetp_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (pix_in.valid),
  .in_ready        (pix_in.ready),
  .out_valid       (pix_out.valid),
  .out_ready       (pix_out.ready),
  .out_column      (pix_out.out_column),
  .out_row         (pix_out.out_row),
  .iteration_count (pix_out.iteration_count),
  .cfg_ready       (cfg.ready)
);

@@ dv/tb_julia_escape_time_pixel.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Julia escape time pixel testbench
// Sends pixel transactions under several register settings, idle and stall patterns.
// Each pixel's escape count is computed in the bench and compared with the
// count transaction returned by the engine, in order.
// ----------------------------------------------------------------------------
module tb_julia_escape_time_pixel;

  localparam logic [jetp_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [jetp_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [jetp_pkg::COORD_W-1:0] column;
    logic [jetp_pkg::COORD_W-1:0] row;
    logic [jetp_pkg::ITER_W-1:0]  count;
  } pixel_count_t;

  logic clk = 1'b0;
  logic rst;

  jetp_in_if  pix_in();
  jetp_out_if pix_out();
  jetp_cfg_if cfg();

  julia_escape_time_pixel u_top (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .cfg     (cfg)
  );

  jetp_pkg::cfg_t regs_shadow;
  pixel_count_t   pending_counts[$];
  int             send_idle_pct;
  int             stall_pct;
  bit             pix_driving;
  int             fail_count;
  int             pixels_sent;
  int             counts_checked;
  int             settings_used;
  int             bounded_pixels;
  int             escaped_pixels;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clamp_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [jetp_pkg::ITER_W-1:0] escape_count(
      input jetp_pkg::cfg_t c,
      input logic [jetp_pkg::COORD_W-1:0] col,
      input logic [jetp_pkg::COORD_W-1:0] row);
    longint          zr, zi, rr, ii, ri, step;
    longint unsigned ar, ai;
    int unsigned     n;
    step = longint'(c.pixel_step);
    zr = clamp_q(longint'($signed(c.origin_real)) + step * longint'(col));
    zi = clamp_q(longint'($signed(c.origin_imag)) + step * longint'(row));
    n = 0;
    while (n < c.max_iter) begin
      ar = (zr < 0) ? -zr : zr;
      ai = (zi < 0) ? -zi : zi;
      if (ar * ar + ai * ai >= jetp_pkg::ESCAPE_Q56) break;
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      zr = clamp_q(((rr - ii) >>> jetp_pkg::FRAC_BITS) + longint'($signed(c.const_real)));
      zi = clamp_q((ri >>> (jetp_pkg::FRAC_BITS - 1)) + longint'($signed(c.const_imag)));
      n++;
    end
    return n[jetp_pkg::ITER_W-1:0];
  endfunction

  function automatic jetp_pkg::cfg_t make_setting(
      input logic [jetp_pkg::Q_W-1:0] o_re, input logic [jetp_pkg::Q_W-1:0] o_im,
      input logic [jetp_pkg::STEP_W-1:0] st,
      input logic [jetp_pkg::Q_W-1:0] c_re, input logic [jetp_pkg::Q_W-1:0] c_im,
      input logic [jetp_pkg::ITER_W-1:0] lim);
    jetp_pkg::cfg_t s;
    s.origin_real = o_re;
    s.origin_imag = o_im;
    s.pixel_step  = st;
    s.const_real  = c_re;
    s.const_imag  = c_im;
    s.max_iter    = lim;
    return s;
  endfunction

  // View of the plane with c near the set, so many pixels iterate for a while
  function automatic jetp_pkg::cfg_t random_view();
    jetp_pkg::cfg_t s;
    longint         centre_re, centre_im, step;
    int unsigned    pick;
    if ($urandom_range(3) == 0) step = $urandom_range(1 << 17, 1 << 19);
    else step = $urandom_range(1 << 10, 1 << 16);
    centre_re = longint'($urandom_range(0, 805306368)) - 402653184;
    centre_im = longint'($urandom_range(0, 805306368)) - 402653184;
    s.origin_real = 32'(centre_re - step * 2048);
    s.origin_imag = 32'(centre_im - step * 2048);
    s.pixel_step  = 31'(step);
    s.const_real  = 32'($urandom_range(0, 322122547)) - 32'd214748365;
    s.const_imag  = 32'($urandom_range(0, 375809638)) - 32'd187904819;
    pick = $urandom_range(99);
    if (pick < 80) s.max_iter = 16'($urandom_range(1, 48));
    else if (pick < 95) s.max_iter = 16'($urandom_range(49, 160));
    else s.max_iter = 16'($urandom_range(161, 300));
    return s;
  endfunction

  function automatic jetp_pkg::cfg_t random_noise();
    jetp_pkg::cfg_t s;
    s.origin_real = $urandom;
    s.origin_imag = $urandom;
    s.pixel_step  = 31'($urandom);
    s.const_real  = $urandom;
    s.const_imag  = $urandom;
    s.max_iter    = 16'($urandom_range(0, 255));
    return s;
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_count(input logic [jetp_pkg::COORD_W-1:0] col,
                             input logic [jetp_pkg::COORD_W-1:0] row,
                             input logic [jetp_pkg::ITER_W-1:0] cnt);
    pixel_count_t want;
    if (pending_counts.size() == 0) begin
      report_failure($sformatf("unexpected count transaction pixel (%0d,%0d) count %0d",
                               col, row, cnt));
      return;
    end
    want = pending_counts.pop_front();
    counts_checked++;
    if (col !== want.column || row !== want.row || cnt !== want.count)
      report_failure($sformatf("got pixel (%0d,%0d) count %0d, expected (%0d,%0d) count %0d",
                               col, row, cnt, want.column, want.row, want.count));
  endtask

  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready)
      check_count(pix_out.out_column, pix_out.out_row, pix_out.iteration_count);
    pix_out.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input logic [jetp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [jetp_pkg::Q_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      jetp_pkg::REG_ORIGIN_REAL: regs_shadow.origin_real = data;
      jetp_pkg::REG_ORIGIN_IMAG: regs_shadow.origin_imag = data;
      jetp_pkg::REG_PIXEL_STEP:  regs_shadow.pixel_step  = data[jetp_pkg::STEP_W-1:0];
      jetp_pkg::REG_CONST_REAL:  regs_shadow.const_real  = data;
      jetp_pkg::REG_CONST_IMAG:  regs_shadow.const_imag  = data;
      jetp_pkg::REG_MAX_ITER:    regs_shadow.max_iter    = data[jetp_pkg::ITER_W-1:0];
      default: ;
    endcase
  endtask

  // Unused data bits above a register's width carry random values
  task automatic program_regs(input jetp_pkg::cfg_t s, input bit spare_writes);
    write_reg(jetp_pkg::REG_ORIGIN_REAL, s.origin_real);
    if (spare_writes) write_reg(REG_SPARE_6, $urandom);
    write_reg(jetp_pkg::REG_ORIGIN_IMAG, s.origin_imag);
    write_reg(jetp_pkg::REG_PIXEL_STEP, {1'($urandom), s.pixel_step});
    write_reg(jetp_pkg::REG_CONST_REAL, s.const_real);
    write_reg(jetp_pkg::REG_CONST_IMAG, s.const_imag);
    if (spare_writes) write_reg(REG_SPARE_7, $urandom);
    write_reg(jetp_pkg::REG_MAX_ITER, {16'($urandom), s.max_iter});
    cfg.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(input logic [jetp_pkg::COORD_W-1:0] col,
                            input logic [jetp_pkg::COORD_W-1:0] row);
    pixel_count_t want;
    pix_in.valid  <= 1'b1;
    pix_in.column <= col;
    pix_in.row    <= row;
    pix_driving = 1'b1;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    want.column = col;
    want.row    = row;
    want.count  = escape_count(regs_shadow, col, row);
    if (want.count == regs_shadow.max_iter) bounded_pixels++;
    else escaped_pixels++;
    pending_counts.push_back(want);
    pixels_sent++;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      if (pix_driving) begin
        pix_in.valid <= 1'b0;
        pix_driving = 1'b0;
      end
      pix_in.column <= 12'($urandom);
      pix_in.row    <= 12'($urandom);
      @(posedge clk);
    end
  endtask

  // Hold off new pixels until every count transaction is back
  task automatic drain_counts();
    if (pix_driving) begin
      pix_in.valid <= 1'b0;
      pix_driving = 1'b0;
    end
    do @(posedge clk); while (pending_counts.size() != 0);
  endtask

  task automatic test_reset_values();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1023, 12'd1023);
    send_pixel(12'd512, 12'd300);
    send_pixel(12'd0, 12'd4095);
  endtask

  task automatic test_zero_limit();
    drain_counts();
    program_regs(make_setting(32'd0, 32'd0, 31'd0, 32'd0, 32'd0, 16'd0), 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain_counts();
    program_regs(make_setting(32'd0, 32'd0, 31'd0, 32'd0, 32'd0, 16'd1), 1'b0);
    send_pixel(12'd7, 12'd9);
  endtask

  // Origin fixed point with c = 0 never escapes: full 16-bit count
  task automatic test_no_escape_long();
    drain_counts();
    program_regs(make_setting(32'd0, 32'd0, 31'd0, 32'd0, 32'd0, 16'hFFFF), 1'b0);
    send_pixel(12'd4095, 12'd0);
  endtask

  task automatic test_start_outside();
    drain_counts();
    // column 1 lands exactly on radius 2, column 0 just inside
    program_regs(make_setting(32'h1FFF_FFFF, 32'd0, 31'd1, 32'd0, 32'd0, 16'd8), 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd4095);
    drain_counts();
    program_regs(make_setting(32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 32'd0, 32'd0, 16'd4),
                 1'b0);
    send_pixel(12'd0, 12'd0);
  endtask

  task automatic test_saturation();
    drain_counts();
    program_regs(make_setting(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 32'd0, 32'd0,
                              16'd40), 1'b0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd2, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    drain_counts();
    program_regs(make_setting(32'h1E66_6666, 32'd0, 31'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              16'd16), 1'b0);
    send_pixel(12'd0, 12'd0);
    drain_counts();
    program_regs(make_setting(32'h1666_6666, 32'h1666_6666, 31'd0, 32'h8000_0000,
                              32'h7FFF_FFFF, 16'd16), 1'b0);
    send_pixel(12'd0, 12'd0);
  endtask

  task automatic test_unknown_index();
    drain_counts();
    program_regs(make_setting(jetp_pkg::RST_ORIGIN_REAL, jetp_pkg::RST_ORIGIN_IMAG,
                              jetp_pkg::RST_PIXEL_STEP, jetp_pkg::RST_CONST_REAL,
                              jetp_pkg::RST_CONST_IMAG, 16'd24), 1'b1);
    send_pixel(12'd100, 12'd200);
    send_pixel(12'd600, 12'd500);
    send_pixel(12'd2048, 12'd1024);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct_in,
                                     input int items);
    int             done;
    int             burst;
    jetp_pkg::cfg_t s;
    send_idle_pct = idle_pct;
    stall_pct     = stall_pct_in;
    done = 0;
    while (done < items) begin
      drain_counts();
      if ($urandom_range(99) < 75) s = random_view();
      else s = random_noise();
      program_regs(s, $urandom_range(3) == 0);
      burst = $urandom_range(20, 70);
      if (burst > items - done) burst = items - done;
      repeat (burst) send_pixel(12'($urandom), 12'($urandom));
      done += burst;
    end
  endtask

  initial begin
    rst            = 1'b1;
    pix_in.valid   = 1'b0;
    pix_in.column  = '0;
    pix_in.row     = '0;
    pix_out.ready  = 1'b0;
    cfg.valid      = 1'b0;
    cfg.index      = '0;
    cfg.data       = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    pix_driving    = 1'b0;
    fail_count     = 0;
    pixels_sent    = 0;
    counts_checked = 0;
    settings_used  = 0;
    bounded_pixels = 0;
    escaped_pixels = 0;
    regs_shadow = make_setting(jetp_pkg::RST_ORIGIN_REAL, jetp_pkg::RST_ORIGIN_IMAG,
                               jetp_pkg::RST_PIXEL_STEP, jetp_pkg::RST_CONST_REAL,
                               jetp_pkg::RST_CONST_IMAG, jetp_pkg::RST_MAX_ITER);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_zero_limit();
    test_no_escape_long();
    test_start_outside();
    test_saturation();
    test_unknown_index();
    test_random_traffic(0, 0, 263);
    test_random_traffic(59, 0, 263);
    test_random_traffic(0, 59, 263);
    test_random_traffic(28, 28, 263);

    drain_counts();
    repeat (40) @(posedge clk);
    if (pending_counts.size() != 0)
      report_failure($sformatf("%0d count transactions never arrived", pending_counts.size()));
    $display("Checked %0d count transactions from %0d pixels over %0d register settings",
             counts_checked, pixels_sent, settings_used);
    $display("%0d pixels escaped before the limit, %0d ran to the limit",
             escaped_pixels, bounded_pixels);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d count transactions outstanding", pending_counts.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
